[rtl/core/pfx_pkg.sv]
// Shared types, constants and helpers of the postfix evaluator.
// No dependencies; every other file of the block imports this package.
package pfx_pkg;

  // Stack geometry and arithmetic width
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DIV_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned OUT_W       = 32;

  // Operator characters and the digit base
  localparam logic [SYM_W-1:0] SYM_ADD    = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_SUB    = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL    = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV    = 8'h2F;
  localparam logic [SYM_W-1:0] DIGIT_BASE = 8'd48;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       count_t;

  // Per-cell load select
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DN
  } pfx_cell_cmd_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WRITE
  } pfx_state_e;

  // Character code minus the digit base, sign-extended to the value width
  function automatic value_t digit_value(input logic [SYM_W-1:0] sym);
    logic [SYM_W:0] diff;
    diff = {1'b0, sym} - {1'b0, DIGIT_BASE};
    return VALUE_WIDTH'(signed'(diff));
  endfunction

  // Character is one of the four operators
  function automatic logic is_operator(input logic [SYM_W-1:0] sym);
    return (sym == SYM_ADD) || (sym == SYM_SUB) || (sym == SYM_MUL) || (sym == SYM_DIV);
  endfunction

endpackage

[rtl/core/pfx_sym_if.sv]
// Input channel of the postfix evaluator: one expression character per word.
// Depends on pfx_pkg for field widths.
interface pfx_sym_if
  import pfx_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
  modport monitor(input valid, input symbol, input last, input ready);
endinterface

[rtl/core/pfx_res_if.sv]
// Result channel of the postfix evaluator: one word per finished expression.
// Depends on pfx_pkg for field widths.
interface pfx_res_if
  import pfx_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] value;
  logic                    underflow_seen;
  logic                    overflow_seen;
  logic                    divide_by_zero_seen;
  logic                    stack_empty;

  modport source (output valid, output value, output underflow_seen, output overflow_seen,
                  output divide_by_zero_seen, output stack_empty, input ready);
  modport sink   (input valid, input value, input underflow_seen, input overflow_seen,
                  input divide_by_zero_seen, input stack_empty, output ready);
  modport monitor(input valid, input value, input underflow_seen, input overflow_seen,
                  input divide_by_zero_seen, input stack_empty, input ready);
endinterface

[rtl/core/pfx_cell.sv]
// One stack cell: holds one entry and loads from the neighbour above or below.
// Depends on pfx_pkg for the value type and the load select.
module pfx_cell
  import pfx_pkg::*;
(
  input  logic          clk_i,
  input  pfx_cell_cmd_e cmd_i,
  input  value_t        up_i,
  input  value_t        dn_i,
  output value_t        val_o
);

  value_t val_q;
  value_t val_d;

  // Select the next entry
  always_comb begin
    unique case (cmd_i)
      CELL_TAKE_UP: val_d = up_i;
      CELL_TAKE_DN: val_d = dn_i;
      default:      val_d = val_q;
    endcase
  end

  // Hold the entry; contents are undefined until first written
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[rtl/core/pfx_divider.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pfx_pkg for the value width and iteration counter width.
module pfx_divider
  import pfx_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  value_t dividend_i,
  input  value_t divisor_i,
  output logic   done_o,
  output value_t quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  value_t               rem_q, rem_d;
  value_t               quo_q, quo_d;
  value_t               dvs_q, dvs_d;
  logic [VALUE_WIDTH:0] shifted;
  logic [VALUE_WIDTH:0] trial;

  // Shift in the next dividend bit and try a subtraction
  always_comb begin
    shifted = {rem_q, quo_q[VALUE_WIDTH-1]};
    trial   = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[VALUE_WIDTH]) begin
        rem_d = trial[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[VALUE_WIDTH-1:0];
        quo_d = {quo_q[VALUE_WIDTH-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/postfix_expression_evaluator.sv]
// Postfix expression evaluator: sequencer, stack chain, divider, result register.
// Depends on pfx_pkg, pfx_sym_if, pfx_res_if, pfx_cell and pfx_divider.
//
// Usage:
//   sym_i carries one expression character per word (symbol, last). A digit or
//   any other non-operator character is pushed as its code minus 48; + - * /
//   pop a then b and push b op a, wrapping at 32 bits. On the word marked last
//   the top of the stack and the sticky error flags go out on res_o as one
//   word, and the stack is emptied; the flags stay set until reset.
//   Timing: a character passes through accept, execute and write back; a
//   division adds a divide state that waits for the one-bit-per-cycle
//   divider. sym_i.ready is high only while the sequencer is idle, so one
//   character is in flight at a time.
//   Result: the word is registered and appears on res_o the cycle after write back.
//   Stall: res_o is a registered output; a waiting result does not block the
//   next characters, only the write back of a following last word waits until
//   the held result is taken.
//   Reset: rst_ni clears the stack count, the flags, the sequencer and the
//   result valid; stack entries need no clearing as only counted ones are read.
module postfix_expression_evaluator
  import pfx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  pfx_sym_if.sink   sym_i,
  pfx_res_if.source res_o
);

  pfx_state_e state_q, state_d;

  logic [SYM_W-1:0] sym_q, sym_d;
  logic             last_q, last_d;
  value_t           res_q, res_d;
  logic             neg_q, neg_d;
  logic             drop_q, drop_d;
  count_t           count_q, count_d;
  logic [2:0]       flags_q, flags_d;

  logic             out_valid_q, out_valid_d;
  value_t           out_value_q, out_value_d;
  logic             out_empty_q, out_empty_d;
  logic [2:0]       out_flags_q, out_flags_d;

  value_t           cell_val [STACK_DEPTH];
  pfx_cell_cmd_e    cmd_top, cmd_rest;
  value_t           opnd_a, opnd_b, mag_a, mag_b;
  logic             div_start, div_done;
  value_t           div_quo;
  logic             accept, write_go, is_op;
  value_t           top_next;

  assign accept = sym_i.valid && sym_i.ready;
  assign is_op  = is_operator(sym_q);

  // Operands from the two top cells, zero where the stack is short
  assign opnd_a = (count_q >= CNT_W'(1)) ? cell_val[0] : '0;
  assign opnd_b = (count_q >= CNT_W'(2)) ? cell_val[1] : '0;
  assign mag_a  = opnd_a[VALUE_WIDTH-1] ? (~opnd_a + 1'b1) : opnd_a;
  assign mag_b  = opnd_b[VALUE_WIDTH-1] ? (~opnd_b + 1'b1) : opnd_b;

  // Write back may proceed unless a last word finds the result register full
  assign write_go = !(last_q && out_valid_q && !res_o.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  state_d = div_start ? ST_DIV : ST_WRITE;
      ST_DIV:   if (div_done) state_d = ST_WRITE;
      ST_WRITE: if (write_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer
  always_comb begin
    sym_d       = sym_q;
    last_d      = last_q;
    res_d       = res_q;
    neg_d       = neg_q;
    drop_d      = drop_q;
    count_d     = count_q;
    flags_d     = flags_q;
    div_start   = 1'b0;
    cmd_top     = CELL_HOLD;
    cmd_rest    = CELL_HOLD;
    top_next    = drop_q ? cell_val[0] : res_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_value_d = out_value_q;
    out_empty_d = out_empty_q;
    out_flags_d = out_flags_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sym_d  = sym_i.symbol;
          last_d = sym_i.last;
        end
      end
      ST_EXEC: begin
        drop_d = 1'b0;
        neg_d  = opnd_a[VALUE_WIDTH-1] ^ opnd_b[VALUE_WIDTH-1];
        if (is_op) begin
          if (count_q < CNT_W'(2)) flags_d[0] = 1'b1;
          priority if (sym_q == SYM_ADD) begin
            res_d = opnd_b + opnd_a;
          end else if (sym_q == SYM_SUB) begin
            res_d = opnd_b - opnd_a;
          end else if (sym_q == SYM_MUL) begin
            res_d = VALUE_WIDTH'(opnd_b * opnd_a);
          end else if (opnd_a == '0) begin
            res_d      = '0;
            flags_d[2] = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end else begin
          res_d = digit_value(sym_q);
          if (count_q == CNT_W'(STACK_DEPTH)) begin
            drop_d     = 1'b1;
            flags_d[1] = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) res_d = neg_q ? (~div_quo + 1'b1) : div_quo;
      end
      ST_WRITE: begin
        if (write_go) begin
          // Update the chain and the count
          if (is_op) begin
            cmd_top  = CELL_TAKE_UP;
            cmd_rest = CELL_TAKE_DN;
            count_d  = (count_q >= CNT_W'(2)) ? (count_q - 1'b1) : CNT_W'(1);
          end else if (!drop_q) begin
            cmd_top  = CELL_TAKE_UP;
            cmd_rest = CELL_TAKE_UP;
            count_d  = count_q + 1'b1;
          end
          // Report the top and empty the stack on the last word
          if (last_q) begin
            out_valid_d = 1'b1;
            out_empty_d = (count_d == '0);
            out_value_d = out_empty_d ? '0 : top_next;
            out_flags_d = flags_q;
            count_d     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Stack chain
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    value_t up_val, dn_val;
    if (i == 0) begin : g_top
      assign up_val = res_q;
    end else begin : g_inner
      assign up_val = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign dn_val = cell_val[i];
    end else begin : g_upper
      assign dn_val = cell_val[i+1];
    end
    pfx_cell u_cell (
      .clk_i (clk_i),
      .cmd_i ((i == 0) ? cmd_top : cmd_rest),
      .up_i  (up_val),
      .dn_i  (dn_val),
      .val_o (cell_val[i])
    );
  end

  // Shared divider on magnitudes
  pfx_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_b),
    .divisor_i  (mag_a),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    last_q      <= last_d;
    res_q       <= res_d;
    neg_q       <= neg_d;
    drop_q      <= drop_d;
    out_value_q <= out_value_d;
    out_empty_q <= out_empty_d;
    out_flags_q <= out_flags_d;
  end

  // Channel outputs
  assign sym_i.ready               = (state_q == ST_IDLE);
  assign res_o.valid               = out_valid_q;
  assign res_o.value               = OUT_W'(signed'(out_value_q));
  assign res_o.underflow_seen      = out_flags_q[0];
  assign res_o.overflow_seen       = out_flags_q[1];
  assign res_o.divide_by_zero_seen = out_flags_q[2];
  assign res_o.stack_empty         = out_empty_q;

endmodule

[rtl/core/pfx_checker.sv]
// Port-level checks of the postfix evaluator, bound to the top level.
// Depends on pfx_pkg; taps the handshakes of both channels, the last marker and the result payload.
module pfx_checker
  import pfx_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             sym_valid_i,
  input logic             sym_ready_i,
  input logic             sym_last_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [OUT_W-1:0] res_value_i,
  input logic             res_underflow_i,
  input logic             res_overflow_i,
  input logic             res_div_zero_i,
  input logic             res_empty_i
);

  logic [1:0] pend_q;
  logic [2:0] seen_q;
  logic       sym_acc, sym_last, res_acc;

  assign sym_acc  = sym_valid_i && sym_ready_i;
  assign sym_last = sym_acc && sym_last_i;
  assign res_acc  = res_valid_i && res_ready_i;

  // Track last words not yet answered and flags already reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      seen_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, sym_last} - {1'b0, res_acc};
      if (res_acc) begin
        seen_q <= seen_q | {res_div_zero_i, res_overflow_i, res_underflow_i};
      end
    end
  end

  // A stalled word holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_value_i))
    else $error("result word changed while stalled");

  // Every result answers a last word
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pend_q != 2'd0)
    else $error("result word without a last character");

  // An empty stack reports zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_empty_i |-> res_value_i == '0)
    else $error("empty stack reported a non-zero value");

  // Flags stay set once reported
  a_flags_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_underflow_i || !seen_q[0]) &&
                    (res_overflow_i || !seen_q[1]) &&
                    (res_div_zero_i || !seen_q[2]))
    else $error("sticky flag cleared");

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .sym_valid_i     (sym_i.valid),
  .sym_ready_i     (sym_i.ready),
  .sym_last_i      (sym_i.last),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_value_i     (res_o.value),
  .res_underflow_i (res_o.underflow_seen),
  .res_overflow_i  (res_o.overflow_seen),
  .res_div_zero_i  (res_o.divide_by_zero_seen),
  .res_empty_i     (res_o.stack_empty)
);
